@@ src/ladder_keypad_debouncer_macros.svh @@
// Assertion macros shared by the keypad debouncer RTL.
// No dependencies; include by bare file name where assertions are written.
`ifndef LADDER_KEYPAD_DEBOUNCER_MACROS_SVH
`define LADDER_KEYPAD_DEBOUNCER_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset
`define LKD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, disabled during reset
`define LKD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define LKD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg)
`define LKD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

@@ src/lkd_pkg.sv @@
// Types and constants for the ladder keypad debouncer.
// No dependencies; imported by lkd_regs, ladder_keypad_debouncer and the testbench.
package lkd_pkg;

  // Key codes as reported on stable_key
  typedef logic [2:0] key_t;
  localparam key_t KEY_NONE   = 3'd0;
  localparam key_t KEY_RIGHT  = 3'd1;
  localparam key_t KEY_UP     = 3'd2;
  localparam key_t KEY_DOWN   = 3'd3;
  localparam key_t KEY_LEFT   = 3'd4;
  localparam key_t KEY_SELECT = 3'd5;

  // Wire codes as reported on press_code
  typedef logic [2:0] wire_code_t;
  localparam wire_code_t WIRE_RIGHT  = 3'd0;
  localparam wire_code_t WIRE_UP     = 3'd1;
  localparam wire_code_t WIRE_DOWN   = 3'd2;
  localparam wire_code_t WIRE_LEFT   = 3'd3;
  localparam wire_code_t WIRE_SELECT = 3'd4;
  localparam wire_code_t WIRE_IDLE   = 3'd0;

  // Largest ADC reading taken as a valid sample
  localparam int unsigned ADC_FULL_SCALE = 1023;

  // Settle count saturation value
  localparam logic [7:0] COUNT_MAX = 8'd255;

  // APB register map (word index = paddr[ADDR_W-1:2])
  localparam int unsigned ADDR_W = 5;
  typedef logic [2:0] reg_idx_t;
  localparam reg_idx_t REG_RIGHT_MAX    = 3'd0;
  localparam reg_idx_t REG_UP_MAX       = 3'd1;
  localparam reg_idx_t REG_DOWN_MAX     = 3'd2;
  localparam reg_idx_t REG_LEFT_MAX     = 3'd3;
  localparam reg_idx_t REG_SELECT_MAX   = 3'd4;
  localparam reg_idx_t REG_SETTLE_MS    = 3'd5;
  localparam reg_idx_t REG_ACCEPT_COUNT = 3'd6;

  // Configuration handed from the register file to the datapath
  typedef struct packed {
    logic [9:0]  right_max;
    logic [9:0]  up_max;
    logic [9:0]  down_max;
    logic [9:0]  left_max;
    logic [9:0]  select_max;
    logic [15:0] settle_ms;
    logic [7:0]  accept_count;
  } cfg_t;

  // Map a key to its wire code; no key maps to zero
  function automatic wire_code_t wire_code(input key_t key);
    wire_code_t code;
    case (key)
      KEY_RIGHT:  code = WIRE_RIGHT;
      KEY_UP:     code = WIRE_UP;
      KEY_DOWN:   code = WIRE_DOWN;
      KEY_LEFT:   code = WIRE_LEFT;
      KEY_SELECT: code = WIRE_SELECT;
      default:    code = WIRE_IDLE;
    endcase
    return code;
  endfunction

endpackage

@@ src/lkd_regs.sv @@
// APB configuration register file for the ladder keypad debouncer.
// Depends on lkd_pkg for the register map and the cfg_t struct.
module lkd_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lkd_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output lkd_pkg::cfg_t               cfg
);
  import lkd_pkg::*;

  cfg_t     cfg_r;
  reg_idx_t idx;
  logic     wr_en;

  assign idx    = paddr[ADDR_W-1:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  // Register writes on the access beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.right_max    <= 10'd200;
      cfg_r.up_max       <= 10'd400;
      cfg_r.down_max     <= 10'd550;
      cfg_r.left_max     <= 10'd650;
      cfg_r.select_max   <= 10'd745;
      cfg_r.settle_ms    <= 16'd50;
      cfg_r.accept_count <= 8'd3;
    end else if (wr_en) begin
      unique case (idx)
        REG_RIGHT_MAX:    cfg_r.right_max    <= pwdata[9:0];
        REG_UP_MAX:       cfg_r.up_max       <= pwdata[9:0];
        REG_DOWN_MAX:     cfg_r.down_max     <= pwdata[9:0];
        REG_LEFT_MAX:     cfg_r.left_max     <= pwdata[9:0];
        REG_SELECT_MAX:   cfg_r.select_max   <= pwdata[9:0];
        REG_SETTLE_MS:    cfg_r.settle_ms    <= pwdata[15:0];
        REG_ACCEPT_COUNT: cfg_r.accept_count <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Read mux; unmapped words read as zero
  always_comb begin
    unique case (idx)
      REG_RIGHT_MAX:    prdata = {22'd0, cfg_r.right_max};
      REG_UP_MAX:       prdata = {22'd0, cfg_r.up_max};
      REG_DOWN_MAX:     prdata = {22'd0, cfg_r.down_max};
      REG_LEFT_MAX:     prdata = {22'd0, cfg_r.left_max};
      REG_SELECT_MAX:   prdata = {22'd0, cfg_r.select_max};
      REG_SETTLE_MS:    prdata = {16'd0, cfg_r.settle_ms};
      REG_ACCEPT_COUNT: prdata = {24'd0, cfg_r.accept_count};
      default:          prdata = 32'd0;
    endcase
  end

endmodule

@@ src/ladder_keypad_debouncer.sv @@
// Ladder keypad debouncer: input register, classify/debounce logic, result register.
// A beat passes the input register, then the result register; throughput 1 sample per cycle
// while out_ready holds, set by the state update between the input and result registers.
// Both stages stall only on out_ready; a full pipe still takes a beat when it drains.
// Reset (rst_n, synchronous, active low) restores all thresholds and clears key state.
// Depends on lkd_pkg, lkd_regs and ladder_keypad_debouncer_macros.svh.
`include "ladder_keypad_debouncer_macros.svh"
module ladder_keypad_debouncer #(
  parameter int TIME_BITS = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // sample channel
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic signed [15:0]          in_sample_value,
  input  logic [31:0]                 in_now_ms,
  // result channel
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [2:0]                  out_stable_key,
  output logic                        out_press_event,
  output logic [2:0]                  out_press_code,
  // configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lkd_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import lkd_pkg::*;

  // Stored timestamp width: the port carries 32 bits at most
  localparam int TW = (TIME_BITS < 32) ? TIME_BITS : 32;

  cfg_t cfg;

  lkd_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Input stage
  logic               a_valid_r;
  logic [15:0]        a_sample_r;
  logic [31:0]        a_now_r;
  logic               a_adv;

  // Result stage
  logic               out_valid_r;
  key_t               out_key_r;
  logic               out_event_r;
  wire_code_t         out_code_r;

  // Debounce state
  key_t               raw_prev_r, raw_prev_nxt;
  logic [TW-1:0]      start_r, start_nxt;
  logic [7:0]         count_r, count_nxt;
  key_t               held_r, held_nxt;
  key_t               reported_r, reported_nxt;
  logic               press_nxt;
  wire_code_t         code_nxt;

  // Datapath temporaries
  logic               in_range;
  key_t               raw;
  logic [TW-1:0]      now_tw;
  logic [TIME_BITS-1:0] elapsed;
  logic               settled;
  logic [7:0]         count_inc;

  // Handshake: input stage moves on when the result stage is free or draining
  assign a_adv    = a_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !a_valid_r || a_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (in_ready) begin
      a_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      a_sample_r <= in_sample_value;
      a_now_r    <= in_now_ms;
    end
  end

  // Range check and threshold classification, first match wins
  assign in_range = !a_sample_r[15] &&
                    ({1'b0, a_sample_r} <= 17'(ADC_FULL_SCALE));

  always_comb begin
    if (a_sample_r <= {6'd0, cfg.right_max}) begin
      raw = KEY_RIGHT;
    end else if (a_sample_r <= {6'd0, cfg.up_max}) begin
      raw = KEY_UP;
    end else if (a_sample_r <= {6'd0, cfg.down_max}) begin
      raw = KEY_DOWN;
    end else if (a_sample_r <= {6'd0, cfg.left_max}) begin
      raw = KEY_LEFT;
    end else if (a_sample_r <= {6'd0, cfg.select_max}) begin
      raw = KEY_SELECT;
    end else begin
      raw = KEY_NONE;
    end
  end

  // Elapsed time wraps at TIME_BITS
  assign now_tw    = a_now_r[TW-1:0];
  assign elapsed   = TIME_BITS'(now_tw) - TIME_BITS'(start_r);
  assign settled   = (elapsed >= TIME_BITS'(cfg.settle_ms));
  assign count_inc = (count_r != COUNT_MAX) ? (count_r + 8'd1) : count_r;

  // Next debounce state and press detection
  always_comb begin
    raw_prev_nxt = raw_prev_r;
    start_nxt    = start_r;
    count_nxt    = count_r;
    held_nxt     = held_r;
    if (in_range) begin
      if (raw != raw_prev_r) begin
        raw_prev_nxt = raw;
        start_nxt    = now_tw;
        count_nxt    = 8'd0;
      end else if (settled) begin
        count_nxt = count_inc;
        if (count_inc >= cfg.accept_count) begin
          held_nxt = raw;
        end
      end
    end
    press_nxt    = (held_nxt != reported_r) && (held_nxt != KEY_NONE);
    reported_nxt = press_nxt ? held_nxt : reported_r;
    code_nxt     = press_nxt ? wire_code(held_nxt) : WIRE_IDLE;
  end

  // State commits as the beat leaves the input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      raw_prev_r <= KEY_NONE;
      start_r    <= '0;
      count_r    <= 8'd0;
      held_r     <= KEY_NONE;
      reported_r <= KEY_NONE;
    end else if (a_adv) begin
      raw_prev_r <= raw_prev_nxt;
      start_r    <= start_nxt;
      count_r    <= count_nxt;
      held_r     <= held_nxt;
      reported_r <= reported_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (a_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (a_adv) begin
      out_key_r   <= held_nxt;
      out_event_r <= press_nxt;
      out_code_r  <= code_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_stable_key  = out_key_r;
  assign out_press_event = out_event_r;
  assign out_press_code  = out_code_r;

  // Checks
  `LKD_ASSERT_NOW(a_press_needs_key, clk, rst_n, out_valid_r && out_event_r, out_key_r != KEY_NONE && out_code_r == out_key_r - 3'd1, "press beat with bad key or code")
  `LKD_ASSERT_NOW(a_ready_when_empty, clk, rst_n, !out_valid_r, in_ready, "input stalled with empty result stage")
  `LKD_ASSERT_NEXT(a_held_only_on_adv, clk, rst_n, !a_adv, $stable(held_r) && $stable(reported_r), "key state moved without a beat")
  `LKD_ASSERT_NEXT(a_count_saturates, clk, rst_n, a_adv && in_range && raw == raw_prev_r && count_r == COUNT_MAX, count_r == COUNT_MAX, "settle count wrapped")

endmodule

@@ dv/tb_ladder_keypad_debouncer.sv @@
// Testbench for ladder_keypad_debouncer: directed and random ADC sample beats under
// several APB register settings, checked beat by beat against a scoreboard predictor.
// Depends on lkd_pkg and the ladder_keypad_debouncer RTL.
module tb_ladder_keypad_debouncer;
  import lkd_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned HOLD_CYCLES  = 80;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned MAX_REPORTS  = 10;
  localparam int unsigned RESET_CYCLES = 7;
  // Word address past the register map; writes there must be ignored
  localparam reg_idx_t    REG_UNUSED   = 3'd7;

  typedef struct packed {
    key_t       stable_key;
    logic       press_event;
    wire_code_t press_code;
  } key_report_t;

  // Predicts the debounced key and press event for each accepted sample beat
  class keypad_scoreboard;
    cfg_t          cfg;
    key_t          raw_prev;
    key_t          held;
    key_t          reported;
    logic [31:0]   settle_start;
    logic [7:0]    settle_cnt;
    key_report_t   expected_q[$];
    int unsigned   errors;

    function new();
      cfg.right_max    = 10'd200;
      cfg.up_max       = 10'd400;
      cfg.down_max     = 10'd550;
      cfg.left_max     = 10'd650;
      cfg.select_max   = 10'd745;
      cfg.settle_ms    = 16'd50;
      cfg.accept_count = 8'd3;
      raw_prev     = KEY_NONE;
      held         = KEY_NONE;
      reported     = KEY_NONE;
      settle_start = '0;
      settle_cnt   = '0;
      errors       = 0;
    endfunction

    function logic [31:0] reg_value(reg_idx_t idx);
      case (idx)
        REG_RIGHT_MAX:    return {22'd0, cfg.right_max};
        REG_UP_MAX:       return {22'd0, cfg.up_max};
        REG_DOWN_MAX:     return {22'd0, cfg.down_max};
        REG_LEFT_MAX:     return {22'd0, cfg.left_max};
        REG_SELECT_MAX:   return {22'd0, cfg.select_max};
        REG_SETTLE_MS:    return {16'd0, cfg.settle_ms};
        REG_ACCEPT_COUNT: return {24'd0, cfg.accept_count};
        default:          return '0;
      endcase
    endfunction

    function void write_reg(reg_idx_t idx, logic [31:0] val);
      case (idx)
        REG_RIGHT_MAX:    cfg.right_max    = val[9:0];
        REG_UP_MAX:       cfg.up_max       = val[9:0];
        REG_DOWN_MAX:     cfg.down_max     = val[9:0];
        REG_LEFT_MAX:     cfg.left_max     = val[9:0];
        REG_SELECT_MAX:   cfg.select_max   = val[9:0];
        REG_SETTLE_MS:    cfg.settle_ms    = val[15:0];
        REG_ACCEPT_COUNT: cfg.accept_count = val[7:0];
        default: ;
      endcase
    endfunction

    // Thresholds are tried in key order; first match wins even if out of order
    function key_t classify(logic [9:0] v);
      if (v <= cfg.right_max)  return KEY_RIGHT;
      if (v <= cfg.up_max)     return KEY_UP;
      if (v <= cfg.down_max)   return KEY_DOWN;
      if (v <= cfg.left_max)   return KEY_LEFT;
      if (v <= cfg.select_max) return KEY_SELECT;
      return KEY_NONE;
    endfunction

    function void note_sample(logic signed [15:0] sample, logic [31:0] now_ms);
      key_report_t r;
      key_t        raw;
      int          v;
      v = int'(sample);
      // Out-of-range readings leave the debounce state alone
      if (v >= 0 && v <= int'(ADC_FULL_SCALE)) begin
        raw = classify(sample[9:0]);
        if (raw != raw_prev) begin
          raw_prev     = raw;
          settle_start = now_ms;
          settle_cnt   = '0;
        end else if (now_ms - settle_start >= {16'd0, cfg.settle_ms}) begin
          if (settle_cnt != COUNT_MAX) settle_cnt++;
          if (settle_cnt >= cfg.accept_count) held = raw;
        end
      end
      // Press check runs on every beat; releases are never reported
      r.press_event = 1'b0;
      r.press_code  = WIRE_IDLE;
      if (held != reported && held != KEY_NONE) begin
        reported      = held;
        r.press_event = 1'b1;
        // wire codes follow key order, starting at right
        r.press_code  = wire_code_t'(held - KEY_RIGHT);
      end
      r.stable_key = held;
      expected_q.push_back(r);
    endfunction

    function void report(string msg);
      errors++;
      if (errors <= MAX_REPORTS) $display("%s", msg);
    endfunction

    function void check_result(key_t key, logic event_bit, wire_code_t code);
      key_report_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected result beat: key %0d event %0d code %0d",
                         key, event_bit, code));
        return;
      end
      want = expected_q.pop_front();
      if (key !== want.stable_key || event_bit !== want.press_event ||
          code !== want.press_code)
        report($sformatf("result mismatch: expected key %0d event %0d code %0d, got %0d %0d %0d",
                         want.stable_key, want.press_event, want.press_code,
                         key, event_bit, code));
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic signed [15:0]         in_sample_value = '0;
  logic [31:0]                in_now_ms = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic [2:0]                 out_stable_key;
  logic                       out_press_event;
  logic [2:0]                 out_press_code;
  logic                       psel = 1'b0;
  logic                       penable = 1'b0;
  logic                       pwrite = 1'b0;
  logic [ADDR_W-1:0]          paddr = '0;
  logic [31:0]                pwdata = '0;
  logic [31:0]                prdata;
  logic                       pready;

  keypad_scoreboard sb;
  bit               idle_on = 1'b1;
  bit               hold_req = 1'b0;
  logic [31:0]      sim_ms = '0;
  int unsigned      cycles = 0;

  ladder_keypad_debouncer dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_sample_value (in_sample_value),
    .in_now_ms       (in_now_ms),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_stable_key  (out_stable_key),
    .out_press_event (out_press_event),
    .out_press_code  (out_press_code),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Result beats go to the scoreboard at the edge they are taken
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_result(out_stable_key, out_press_event, out_press_code);
  end

  // Receiver: random stall bursts, plus one long hold-off on request
  initial begin
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Watchdog
  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("status: fail");
    $finish;
  end

  function automatic int clip_adc(int x);
    if (x < 0) return 0;
    if (x > int'(ADC_FULL_SCALE)) return int'(ADC_FULL_SCALE);
    return x;
  endfunction

  // One sample beat; returns at the edge where it is taken
  task automatic send_sample(input logic signed [15:0] sample, input logic [31:0] now_ms);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_sample_value <= sample;
    in_now_ms       <= now_ms;
    do @(posedge clk); while (!in_ready);
    sb.note_sample(sample, now_ms);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // APB write then read-back; psel stays high so transfers chain back to back
  task automatic cfg_set(input reg_idx_t idx, input logic [31:0] val);
    logic [31:0] rd;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.write_reg(idx, val);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rd = prdata;
    if (idx != REG_UNUSED && rd !== sb.reg_value(idx))
      sb.report($sformatf("register %0d read back %0h, expected %0h",
                          idx, rd, sb.reg_value(idx)));
  endtask

  task automatic cfg_release();
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Ascending random thresholds
  task automatic cfg_random_thresholds();
    int v;
    v = $urandom_range(0, 300);
    cfg_set(REG_RIGHT_MAX, v);
    v = clip_adc(v + int'($urandom_range(0, 250)));
    cfg_set(REG_UP_MAX, v);
    v = clip_adc(v + int'($urandom_range(0, 250)));
    cfg_set(REG_DOWN_MAX, v);
    v = clip_adc(v + int'($urandom_range(0, 250)));
    cfg_set(REG_LEFT_MAX, v);
    v = clip_adc(v + int'($urandom_range(0, 250)));
    cfg_set(REG_SELECT_MAX, v);
  endtask

  // Key holds: runs of one reading with bounce and out-of-range noise mixed in
  task automatic gen_burst(input int n, input int step_max, input int run_min,
                           input int run_max, input bit bounce);
    int                 sent;
    int                 len;
    int                 v;
    int                 sv;
    logic [31:0]        rnd;
    logic signed [15:0] s;
    sent = 0;
    while (sent < n) begin
      v   = $urandom_range(0, ADC_FULL_SCALE);
      len = $urandom_range(run_min, run_max);
      for (int i = 0; i < len && sent < n; i++) begin
        case ($urandom_range(0, 9))
          0: begin
            rnd = $urandom;
            s   = rnd[15:0];
          end
          1: begin
            if (bounce) s = 16'(clip_adc(v + int'($urandom_range(0, 80)) - 40));
            else s = 16'(v);
          end
          default: s = 16'(v);
        endcase
        if ($urandom_range(0, 19) == 0) sim_ms = $urandom;
        else sim_ms = sim_ms + $urandom_range(0, step_max);
        send_sample(s, sim_ms);
        sv = int'(s);
        if (sv >= 0 && sv <= int'(ADC_FULL_SCALE)) sent++;
      end
    end
  endtask

  initial begin
    int dir_val [16];
    int dir_ms  [16];
    int key_val [8];
    sb = new();
    dir_val = '{700, 745, -32768, 32767, 1024, -1, 700, 740,
                746, 1023, 1023, 1023, 745, 745, 745, 745};
    dir_ms  = '{100, 150, 155, 156, 157, 158, 160, 170,
                180, 230, 240, 250, 260, 310, 320, 330};
    key_val = '{0, 200, 201, 400, 401, 550, 551, 650};

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: select press, rejected readings, release, select held again with no second press
    for (int i = 0; i < 16; i++) send_sample(dir_val[i][15:0], dir_ms[i]);
    drain_results();

    // Immediate accept: each remaining key at its band edges, time wrapping
    cfg_set(REG_SETTLE_MS, 32'd0);
    cfg_set(REG_ACCEPT_COUNT, 32'd1);
    cfg_release();
    for (int i = 0; i < 8; i++) send_sample(key_val[i][15:0], 32'hFFFF_FFF8 + 2 * i);
    drain_results();

    // Reset thresholds, normal debounce, long receiver hold-off
    cfg_set(REG_SETTLE_MS, 32'd50);
    cfg_set(REG_ACCEPT_COUNT, 32'd3);
    cfg_release();
    sim_ms  = 32'd1000;
    hold_req = 1'b1;
    gen_burst(160, 30, 3, 20, 1'b1);
    drain_results();

    // Out-of-order and extreme thresholds, accept on first settled beat
    cfg_set(REG_RIGHT_MAX, 32'd0);
    cfg_set(REG_UP_MAX, 32'd300);
    cfg_set(REG_DOWN_MAX, 32'd100);
    cfg_set(REG_LEFT_MAX, 32'hFFFF_FFFF);
    cfg_set(REG_SELECT_MAX, 32'hA5A5_A400);
    cfg_set(REG_SETTLE_MS, 32'd0);
    cfg_set(REG_ACCEPT_COUNT, 32'd0);
    cfg_set(REG_UNUSED, 32'h5A5A_5A5A);
    cfg_release();
    gen_burst(80, 5, 2, 12, 1'b1);
    drain_results();

    // Longest settle time with the millisecond clock wrapping
    cfg_random_thresholds();
    cfg_set(REG_SETTLE_MS, 32'h0000_FFFF);
    cfg_set(REG_ACCEPT_COUNT, 32'd1);
    cfg_release();
    sim_ms = 32'hFFFE_0000;
    gen_burst(80, 20000, 8, 30, 1'b1);
    drain_results();

    // Largest accept count: long steady hold that saturates the count
    cfg_set(REG_SETTLE_MS, 32'd0);
    cfg_set(REG_ACCEPT_COUNT, 32'hFFFF_FFFF);
    cfg_release();
    gen_burst(280, 10, 260, 275, 1'b0);
    drain_results();

    // Random settings, full rate on both sides
    idle_on = 1'b0;
    cfg_random_thresholds();
    cfg_set(REG_SETTLE_MS, $urandom_range(0, 80));
    cfg_set(REG_ACCEPT_COUNT, $urandom_range(1, 6));
    cfg_release();
    gen_burst(120, 30, 3, 20, 1'b1);
    drain_results();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
